FILE: src/prfc_pkg.sv
package prfc_pkg;

  localparam int unsigned ChanW = 32;
  localparam int unsigned PackW = 64;

  typedef enum logic [2:0] {
    FMT_RGBA8    = 3'd0,
    FMT_RGBA16F  = 3'd1,
    FMT_RGBA32F  = 3'd2,
    FMT_RGBA16UI = 3'd3,
    FMT_RGBA32UI = 3'd4
  } fmt_t;

  localparam logic ACT_FLOAT = 1'b0;
  localparam logic ACT_PACK  = 1'b1;

  // Per-channel intermediate after the classify stage.
  typedef struct packed {
    logic        zero;   // result is +0
    logic        pass;   // result is raw word as is
    logic [31:0] raw;    // pass-through word or prebuilt half or unorm8 result
    logic        is_int; // integer conversion path
    logic [31:0] ival;   // integer to convert
    logic [4:0]  msb;    // leading one position of ival
  } chan_mid_t;

  // Per-channel after the shift stage.
  typedef struct packed {
    logic        direct; // take word as final
    logic [31:0] word;
    logic [7:0]  expo;
    logic [23:0] mant;   // with hidden bit
    logic        up;     // round increment
  } chan_rnd_t;

  // 8-bit unorm to single, 256-entry constant table, correctly rounded.
  function automatic logic [31:0] unorm8_lut(input logic [7:0] n);
    logic [31:0] k;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    k = 32'd1;
    num = '0;
    q = '0;
    rem = '0;
    if (n == 8'd0) return 32'd0;
    if (n == 8'd255) return 32'h3F80_0000;
    for (int i = 0; i < 8; i++) begin
      if (({24'd0, n} << k) < 32'd255) k = k + 32'd1;
    end
    num = {56'd0, n} << (23 + k);
    q = num / 64'd255;
    rem = num % 64'd255;
    if (2 * rem > 64'd255) q = q + 64'd1;
    return 32'(((64'(127) - 64'(k)) << 23) + (q - 64'h0080_0000));
  endfunction

  // Build the whole table at elaboration, entry n at bits [32*n +: 32].
  function automatic logic [32*256-1:0] unorm8_tbl_build();
    logic [32*256-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 256; i++) tbl[32*i +: 32] = unorm8_lut(8'(i));
    return tbl;
  endfunction

  localparam logic [32*256-1:0] Unorm8Tbl = unorm8_tbl_build();

  // Half to single; leading-one search over 10 bits only.
  function automatic logic [31:0] half_widen(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [9:0]  sh;
    sgn = {h[15], 31'd0};
    ex = h[14:10];
    man = h[9:0];
    lz = 4'd0;
    sh = '0;
    if (ex == 5'd0) begin
      if (man == 10'd0) return sgn;
      for (int i = 0; i < 10; i++) begin
        if (man[i]) lz = 4'(9 - i);
      end
      sh = man << (lz + 4'd1);
      return sgn | {1'b0, 8'(8'd112 - {4'd0, lz}), sh, 13'd0};
    end
    if (ex == 5'h1F) return sgn | {1'b0, 8'hFF, man, 13'd0};
    return sgn | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
  endfunction

endpackage

FILE: src/pixel_readback_format_converter.sv
// Channel | Dir | Handshake          | Payload
// in      | in  | in_tvalid/tready   | in_tdata: action, pixel_format, red..alpha
// out     | out | out_tvalid/tready  | out_tdata: float r,g,b,a, packed_word
// One pixel per cycle unless out stalls; three register stages (classify,
// normalize, round) lie between a taken pixel and out_tvalid.
// Reset clears the stage valid bits only.
// A stall on out holds only the stages that are full; a bubble is filled while stalled.
module pixel_readback_format_converter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[0], pixel_format[3:1], red[35:4], green[67:36], blue[99:68],
  // alpha[131:100], zero fill [135:132]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // float_red[31:0], float_green[63:32], float_blue[95:64],
  // float_alpha[127:96], packed_word[191:128]
  output logic [191:0] out_tdata
);
  import prfc_pkg::*;

  logic             v1_r, v2_r, v3_r;
  logic             en1, en2, en3;
  chan_mid_t        mid_nxt [4];
  chan_mid_t        mid_r   [4];
  chan_rnd_t        rnd_nxt [4];
  chan_rnd_t        rnd_r   [4];
  logic             act1_r, act2_r;
  logic [PackW-1:0] pk_nxt, pk1_r, pk2_r, pk3_r;
  logic [31:0]      fl_r [4];
  logic [2:0]       fmt;

  assign fmt = in_tdata[3:1];
  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_comb begin
    pk_nxt = '0;
    if (in_tdata[0] == ACT_PACK) begin
      if (fmt == FMT_RGBA16UI)
        pk_nxt = {in_tdata[115:100], in_tdata[83:68], in_tdata[51:36], in_tdata[19:4]};
      else if (fmt == FMT_RGBA32UI)
        pk_nxt = {in_tdata[67:36], in_tdata[35:4]};
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_ch
    prfc_classify u_cls (
      .fmt (fmt),
      .raw (in_tdata[4+32*g +: 32]),
      .mid (mid_nxt[g])
    );
    prfc_normalize u_nrm (
      .mid (mid_r[g]),
      .rnd (rnd_nxt[g])
    );
    always_ff @(posedge clk) begin
      if (en1) mid_r[g] <= mid_nxt[g];
      if (en2) rnd_r[g] <= rnd_nxt[g];
      if (en3) begin
        if (act2_r == ACT_PACK) fl_r[g] <= '0;
        else if (rnd_r[g].direct) fl_r[g] <= rnd_r[g].word;
        else fl_r[g] <= {1'b0, rnd_r[g].expo, rnd_r[g].mant[22:0]}
                        + {31'd0, rnd_r[g].up};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      act1_r <= in_tdata[0];
      pk1_r  <= pk_nxt;
    end
    if (en2) begin
      act2_r <= act1_r;
      pk2_r  <= pk1_r;
    end
    if (en3) pk3_r <= pk2_r;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {pk3_r, fl_r[3], fl_r[2], fl_r[1], fl_r[0]};

endmodule

FILE: src/prfc_classify.sv
module prfc_classify (
  input  logic [2:0]                  fmt,
  input  logic [prfc_pkg::ChanW-1:0]  raw,
  output prfc_pkg::chan_mid_t         mid
);
  import prfc_pkg::*;

  logic [31:0] v;
  logic [4:0]  p;

  always_comb begin
    v = '0;
    mid = '0;
    case (fmt)
      FMT_RGBA8: begin
        mid.pass = 1'b1;
        mid.raw = Unorm8Tbl[{raw[7:0], 5'd0} +: 32];
      end
      FMT_RGBA16F: begin
        mid.pass = 1'b1;
        mid.raw = half_widen(raw[15:0]);
      end
      FMT_RGBA32F: begin
        mid.pass = 1'b1;
        mid.raw = raw;
      end
      FMT_RGBA16UI: v = {16'd0, raw[15:0]};
      FMT_RGBA32UI: v = raw;
      default: mid.zero = 1'b1;
    endcase
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    if (fmt == FMT_RGBA16UI || fmt == FMT_RGBA32UI) begin
      mid.zero = (v == 32'd0);
      mid.is_int = 1'b1;
    end
    mid.ival = v;
    mid.msb = p;
  end

endmodule

FILE: src/prfc_normalize.sv
module prfc_normalize (
  input  prfc_pkg::chan_mid_t mid,
  output prfc_pkg::chan_rnd_t rnd
);
  import prfc_pkg::*;

  logic [4:0]  r;
  logic [31:0] rem;
  logic [31:0] half;
  logic [23:0] q;

  always_comb begin
    rnd = '0;
    r = '0;
    rem = '0;
    half = '0;
    q = '0;
    if (mid.zero) begin
      rnd.direct = 1'b1;
    end else if (!mid.is_int) begin
      rnd.direct = 1'b1;
      rnd.word = mid.raw;
    end else begin
      if (mid.msb <= 5'd23) begin
        q = 24'(mid.ival << (5'd23 - mid.msb));
      end else begin
        r = mid.msb - 5'd23;
        q = 24'(mid.ival >> r);
        rem = mid.ival & ((32'd1 << r) - 32'd1);
        half = 32'd1 << (r - 5'd1);
        rnd.up = (rem > half) || (rem == half && q[0]);
      end
      rnd.expo = 8'(8'd127 + {3'd0, mid.msb});
      rnd.mant = q;
    end
  end

endmodule
